/* sv/lsb_payload_extractor_assert.svh */
// ----------------------------------------------------------------------------
// lsb payload extractor assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef LSB_PAYLOAD_EXTRACTOR_ASSERT_SVH
`define LSB_PAYLOAD_EXTRACTOR_ASSERT_SVH

// clocked check, off while reset is high
`define LSPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs through reset
`define LSPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lspe_pkg.sv */
// ----------------------------------------------------------------------------
// lspe_pkg
// shared widths, codes and types for the lsb payload extractor
// ----------------------------------------------------------------------------
package lspe_pkg;

  localparam int LENGTH_FIELD_BITS = 32;
  localparam int LEN_W    = LENGTH_FIELD_BITS;
  localparam int BITPOS_W = $clog2(LENGTH_FIELD_BITS);
  localparam int CONS_W   = 33;
  localparam int SUM_W    = CONS_W + 3;
  localparam int AUDIO_W  = 32;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int PHASE_W  = 3;

  localparam logic [PHASE_W-1:0] PH_NAME_LEN = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIZE     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

  localparam logic [CONS_W-1:0] CONS_MAX = {CONS_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              last;
  } result_t;

endpackage

/* sv/lspe_frame_fsm.sv */
// ----------------------------------------------------------------------------
// lspe_frame_fsm
// frame state and single-step update for one hidden bit
// ----------------------------------------------------------------------------
module lspe_frame_fsm
  import lspe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               hidden_bit,
  input  logic [AUDIO_W-1:0] audio_bytes,
  output logic               res_valid,
  output result_t            res
);

  logic [PHASE_W-1:0]  phase, phase_next;
  logic [BITPOS_W-1:0] bit_position, bit_position_next;
  logic [LEN_W-1:0]    shift_accumulator, shift_accumulator_next;
  logic [LEN_W-1:0]    field_target, field_target_next;
  logic [LEN_W-1:0]    bytes_done, bytes_done_next;
  logic [CONS_W-1:0]   consumed_count, consumed_count_next;

  logic [CONS_W-1:0]   consumed_inc;
  logic [LEN_W-1:0]    acc_or;
  logic [LEN_W-1:0]    done_inc;
  logic [SUM_W-1:0]    size_sum;
  logic                field_end;
  logic                byte_end;

  assign consumed_inc = (consumed_count == CONS_MAX) ? consumed_count
                                                     : consumed_count + CONS_W'(1);
  assign acc_or    = shift_accumulator | (LEN_W'(hidden_bit) << bit_position);
  assign done_inc  = bytes_done + LEN_W'(1);
  assign field_end = (bit_position == BITPOS_W'(LENGTH_FIELD_BITS - 1));
  assign byte_end  = (bit_position == BITPOS_W'(BYTE_W - 1));
  // sum kept wide so the size check never wraps
  assign size_sum  = SUM_W'(consumed_inc) + (SUM_W'(acc_or) << 3);

  always_comb begin
    phase_next             = phase;
    bit_position_next      = bit_position;
    shift_accumulator_next = shift_accumulator;
    field_target_next      = field_target;
    bytes_done_next        = bytes_done;
    consumed_count_next    = consumed_count;
    res_valid              = 1'b0;
    res                    = '0;
    if (step) begin
      case (phase)
        PH_NAME_LEN, PH_SIZE: begin
          consumed_count_next = consumed_inc;
          if (!field_end) begin
            shift_accumulator_next = acc_or;
            bit_position_next      = bit_position + BITPOS_W'(1);
          end else begin
            shift_accumulator_next = '0;
            bit_position_next      = '0;
            bytes_done_next        = '0;
            if (phase == PH_NAME_LEN) begin
              // top bit set reads as a negative length, taken as zero
              if (acc_or[LEN_W-1]) begin
                field_target_next = '0;
                phase_next        = PH_SIZE;
              end else begin
                field_target_next = acc_or;
                phase_next        = (acc_or != '0) ? PH_NAME : PH_SIZE;
              end
            end else begin
              field_target_next = acc_or;
              if (size_sum > SUM_W'(audio_bytes)) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res.kind   = KIND_INVALID;
              end else if (acc_or == '0) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res.kind   = KIND_EMPTY;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end
        PH_NAME, PH_PAYLOAD: begin
          consumed_count_next = consumed_inc;
          if (!byte_end) begin
            shift_accumulator_next = acc_or;
            bit_position_next      = bit_position + BITPOS_W'(1);
          end else begin
            shift_accumulator_next = '0;
            bit_position_next      = '0;
            res_valid              = 1'b1;
            res.data               = acc_or[BYTE_W-1:0];
            res.kind               = (phase == PH_NAME) ? KIND_NAME : KIND_PAYLOAD;
            if (done_inc == field_target) begin
              res.last        = 1'b1;
              bytes_done_next = '0;
              phase_next      = (phase == PH_NAME) ? PH_SIZE : PH_DONE;
            end else begin
              bytes_done_next = done_inc;
            end
          end
        end
        default: begin
          // frame finished, items are dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_NAME_LEN;
      bit_position      <= '0;
      shift_accumulator <= '0;
      field_target      <= '0;
      bytes_done        <= '0;
      consumed_count    <= '0;
    end else begin
      phase             <= phase_next;
      bit_position      <= bit_position_next;
      shift_accumulator <= shift_accumulator_next;
      field_target      <= field_target_next;
      bytes_done        <= bytes_done_next;
      consumed_count    <= consumed_count_next;
    end
  end

endmodule

/* sv/lsb_payload_extractor.sv */
// ----------------------------------------------------------------------------
// lsb_payload_extractor
// recovers a hidden name and payload from the low bits of audio bytes
// ----------------------------------------------------------------------------
// One audio byte is taken per cycle at full rate unless the result register
// stalls; each accepted item goes through the input register, then the frame
// update into the result register. A result register stall passes straight
// back to in_ready through the input register, so the block keeps one item
// per cycle whenever the sink takes results as they come. Only bit 0 of
// sample_byte is used. Name bytes come out with kind 0, payload bytes with
// kind 1, and last marks the final byte of each. After the size field a
// single kind 2 result flags a size that would run past audio_bytes, or a
// kind 3 result reports an empty payload; after the frame all items are
// consumed and dropped. Write audio_bytes only while the block is idle.
module lsb_payload_extractor
  import lspe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [AUDIO_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  sample_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic [KIND_W-1:0]  kind,
  output logic               last
);

  logic [AUDIO_W-1:0] audio_bytes;
  logic               hold_valid;
  logic               hold_bit;
  logic               advance;
  logic               res_valid;
  result_t            res;
  result_t            out_reg;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_bytes <= '0;
    end else if (cfg_wr_en) begin
      audio_bytes <= cfg_wr_data;
    end
  end

  // input register: only the hidden bit is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_bit <= sample_byte[0];
    end
  end

  lspe_frame_fsm u_frame (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .hidden_bit  (hold_bit),
    .audio_bytes (audio_bytes),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || out_ready) && advance && res_valid) begin
      out_reg <= res;
    end
  end

  assign out_byte = out_reg.data;
  assign kind     = out_reg.kind;
  assign last     = out_reg.last;

endmodule

/* sv/lspe_checker.sv */
// ----------------------------------------------------------------------------
// lspe_checker
// port-level checks on the extractor, attached by bind
// ----------------------------------------------------------------------------
`include "lsb_payload_extractor_assert.svh"

module lspe_checker
  import lspe_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic [KIND_W-1:0] kind,
  input logic              last
);

  logic                     stalled;
  logic                     status_item;
  logic                     frame_end;
  logic [BYTE_W+KIND_W:0]   shown;

  assign stalled     = out_valid && !out_ready;
  assign status_item = out_valid && (kind == KIND_INVALID || kind == KIND_EMPTY);
  assign frame_end   = out_valid && out_ready &&
                       (status_item || (kind == KIND_PAYLOAD && last));
  assign shown       = {out_byte, kind, last};

  `LSPE_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result shown after reset")

  `LSPE_ASSERT(a_out_hold, stalled |=> out_valid && $stable(shown), "stalled result changed")

  `LSPE_ASSERT(a_status_clean, status_item |-> out_byte == '0 && !last, "status item carries data")

  // nothing may follow the end of the frame
  `LSPE_ASSERT(a_frame_end, frame_end |=> !out_valid, "item after end of frame")

endmodule

bind lsb_payload_extractor lspe_checker u_lspe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .kind      (kind),
  .last      (last)
);
